[rtl/core/nfc_response_frame_checker_core_macros.svh]
// Assertion macros shared by the response frame checker RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef NFC_RESPONSE_FRAME_CHECKER_CORE_MACROS_SVH
`define NFC_RESPONSE_FRAME_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NFC_RFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nfc_rfc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define NFC_RFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nfc_rfc: next-cycle check failed");

`endif

[rtl/core/nfc_rfc_pkg.sv]
// Package for the response frame checker: codes, phase enum and shared structs.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package nfc_rfc_pkg;

  // Fixed frame bytes.
  localparam logic [7:0] READY_STATUS  = 8'h01;
  localparam logic [7:0] PREAMBLE_ZERO = 8'h00;
  localparam logic [7:0] START_CODE    = 8'hFF;
  localparam logic [7:0] FRAME_ID      = 8'hD5;
  localparam logic [7:0] POSTAMBLE     = 8'h00;

  // Commands with a fixed payload capacity.
  localparam logic [7:0] CMD_FIRMWARE  = 8'h02;
  localparam logic [7:0] CMD_SAM_CFG   = 8'h14;
  localparam logic [6:0] CAP_FIRMWARE  = 7'd4;
  localparam logic [6:0] CAP_SAM_CFG   = 7'd0;
  localparam logic [6:0] CAP_COUNTER_MAX = 7'd63;

  // Length byte covers the frame id and the command echo.
  localparam logic [7:0] LEN_OVERHEAD  = 8'd2;

  typedef enum logic [0:0] {
    REG_EXPECTED_COMMAND = 1'b0,
    REG_PAYLOAD_CAPACITY = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_BAD_RESPONSE = 2'd1,
    ST_BAD_SIZE     = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_PRE0  = 4'd1,
    PH_PRE1  = 4'd2,
    PH_PREFF = 4'd3,
    PH_LEN   = 4'd4,
    PH_LCS   = 4'd5,
    PH_TFI   = 4'd6,
    PH_CMD   = 4'd7,
    PH_DATA  = 4'd8,
    PH_DCS   = 4'd9,
    PH_POST  = 4'd10
  } phase_t;

  // Configuration view handed to the parser.
  typedef struct packed {
    logic [7:0] expected_command;
    logic [6:0] payload_capacity;
    logic [6:0] capacity;
    logic       capacity_bad;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       verdict_done;
    status_t    verdict_status;
    logic [5:0] payload_length;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/nfc_rfc_cfg.sv]
// Configuration registers and the per-command capacity decode.
// Depends on nfc_rfc_pkg.
`default_nettype none

module nfc_rfc_cfg
  import nfc_rfc_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  output cfg_t            cfg
);

  // Largest capacity that still fits the frame buffer with nine framing bytes.
  localparam int CapLimit = FRAME_BUFFER_BYTES + 1 - 10;

  logic [7:0] expected_command;
  logic [6:0] payload_capacity;
  logic [6:0] capacity;

  assign cfg_ready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= 8'd0;
      payload_capacity <= 7'd24;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_EXPECTED_COMMAND: expected_command <= cfg_data;
        REG_PAYLOAD_CAPACITY: payload_capacity <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Some commands answer with a fixed payload size.
  always_comb begin
    if (expected_command == CMD_FIRMWARE) begin
      capacity = CAP_FIRMWARE;
    end else if (expected_command == CMD_SAM_CFG) begin
      capacity = CAP_SAM_CFG;
    end else begin
      capacity = payload_capacity;
    end
  end

  assign cfg.expected_command = expected_command;
  assign cfg.payload_capacity = payload_capacity;
  assign cfg.capacity         = capacity;
  assign cfg.capacity_bad     = ({1'b0, capacity} > 8'(CapLimit)) ||
                                (capacity > CAP_COUNTER_MAX);

endmodule

`default_nettype wire

[rtl/core/nfc_rfc_parser.sv]
// Frame parser: phase state machine, checksums and payload counter.
// Depends on nfc_rfc_pkg.
`default_nettype none

module nfc_rfc_parser
  import nfc_rfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic       first_byte,
  input  wire cfg_t       cfg,
  output res_t            res
);

  phase_t     phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_sum, running_sum_next;
  logic [5:0] payload_count, payload_count_next;
  logic [5:0] effective_capacity, effective_capacity_next;
  logic       oversize_pending, oversize_pending_next;

  logic [7:0] len_minus2;
  logic [5:0] count_inc;

  // Payload length reported with an ok verdict.
  function automatic logic [5:0] len_minus2_of_frame(input logic [7:0] len);
    logic [7:0] diff;
    diff = len - LEN_OVERHEAD;
    return diff[5:0];
  endfunction

  assign len_minus2 = rx_byte - LEN_OVERHEAD;
  assign count_inc  = payload_count + 6'd1;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_IDLE;
      frame_length       <= 8'd0;
      running_sum        <= 8'd0;
      payload_count      <= 6'd0;
      effective_capacity <= 6'd0;
      oversize_pending   <= 1'b0;
    end else if (step) begin
      phase              <= phase_next;
      frame_length       <= frame_length_next;
      running_sum        <= running_sum_next;
      payload_count      <= payload_count_next;
      effective_capacity <= effective_capacity_next;
      oversize_pending   <= oversize_pending_next;
    end
  end

  // Next state and result for the item at hand.
  always_comb begin
    phase_next              = phase;
    frame_length_next       = frame_length;
    running_sum_next        = running_sum;
    payload_count_next      = payload_count;
    effective_capacity_next = effective_capacity;
    oversize_pending_next   = oversize_pending;
    res                     = '0;

    if (first_byte) begin
      // A new read starts here and drops any open one.
      frame_length_next     = 8'd0;
      running_sum_next      = 8'd0;
      payload_count_next    = 6'd0;
      oversize_pending_next = 1'b0;
      if (cfg.capacity_bad) begin
        effective_capacity_next = 6'd0;
        res.verdict_done        = 1'b1;
        res.verdict_status      = ST_BAD_SIZE;
        phase_next              = PH_IDLE;
      end else begin
        effective_capacity_next = cfg.capacity[5:0];
        if (rx_byte != READY_STATUS) begin
          res.verdict_done   = 1'b1;
          res.verdict_status = ST_BAD_RESPONSE;
          phase_next         = PH_IDLE;
        end else begin
          phase_next = PH_PRE0;
        end
      end
    end else begin
      unique case (phase)
        PH_PRE0, PH_PRE1: begin
          if (rx_byte != PREAMBLE_ZERO) begin
            res.verdict_done   = 1'b1;
            res.verdict_status = ST_BAD_RESPONSE;
            phase_next         = PH_IDLE;
          end else begin
            phase_next = (phase == PH_PRE0) ? PH_PRE1 : PH_PREFF;
          end
        end
        PH_PREFF: begin
          if (rx_byte != START_CODE) begin
            res.verdict_done   = 1'b1;
            res.verdict_status = ST_BAD_RESPONSE;
            phase_next         = PH_IDLE;
          end else begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_length_next     = rx_byte;
          oversize_pending_next = (rx_byte >= LEN_OVERHEAD) &&
                                  ((len_minus2 > {1'b0, cfg.payload_capacity}) ||
                                   (len_minus2 > {2'b00, effective_capacity}));
          phase_next            = PH_LCS;
        end
        PH_LCS: begin
          if ((8'(frame_length + rx_byte) != 8'd0) || (frame_length < LEN_OVERHEAD)) begin
            res.verdict_done   = 1'b1;
            res.verdict_status = ST_BAD_RESPONSE;
            phase_next         = PH_IDLE;
          end else begin
            phase_next = PH_TFI;
          end
        end
        PH_TFI: begin
          if (rx_byte != FRAME_ID) begin
            res.verdict_done   = 1'b1;
            res.verdict_status = ST_BAD_RESPONSE;
            phase_next         = PH_IDLE;
          end else begin
            running_sum_next = rx_byte;
            phase_next       = PH_CMD;
          end
        end
        PH_CMD: begin
          // Oversize is only reported once the command echo has passed.
          if (rx_byte != 8'(cfg.expected_command + 8'd1)) begin
            res.verdict_done   = 1'b1;
            res.verdict_status = ST_BAD_RESPONSE;
            phase_next         = PH_IDLE;
          end else if (oversize_pending) begin
            res.verdict_done   = 1'b1;
            res.verdict_status = ST_BAD_SIZE;
            phase_next         = PH_IDLE;
          end else begin
            running_sum_next   = running_sum + rx_byte;
            payload_count_next = 6'd0;
            phase_next         = (frame_length > LEN_OVERHEAD) ? PH_DATA : PH_DCS;
          end
        end
        PH_DATA: begin
          res.payload_valid  = 1'b1;
          res.payload_byte   = rx_byte;
          res.payload_index  = payload_count;
          running_sum_next   = running_sum + rx_byte;
          payload_count_next = count_inc;
          if (({2'b00, count_inc} + LEN_OVERHEAD) >= frame_length) begin
            phase_next = PH_DCS;
          end
        end
        PH_DCS: begin
          if (8'(running_sum + rx_byte) != 8'd0) begin
            res.verdict_done   = 1'b1;
            res.verdict_status = ST_BAD_RESPONSE;
            phase_next         = PH_IDLE;
          end else begin
            phase_next = PH_POST;
          end
        end
        PH_POST: begin
          res.verdict_done = 1'b1;
          phase_next       = PH_IDLE;
          if (rx_byte != POSTAMBLE) begin
            res.verdict_status = ST_BAD_RESPONSE;
          end else begin
            res.verdict_status = ST_OK;
            res.payload_length = len_minus2_of_frame(frame_length);
          end
        end
        default: begin
          // No read open: the item is ignored.
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/nfc_response_frame_checker_core.sv]
// Top level of the response frame checker: input register, parser, result register.
// Depends on nfc_rfc_pkg, nfc_rfc_cfg, nfc_rfc_parser and the assertion macros header.
`default_nettype none
`include "nfc_response_frame_checker_core_macros.svh"

// Checks one response read of a normal information frame, one byte per item,
// and returns exactly one result item for every input item. A byte with
// first_byte set starts a read; the payload bytes are passed out as they
// arrive and the read ends with a verdict (ok, bad response or bad size).
// The consumer must discard the payload bytes of a read whose verdict is not
// ok. The block takes one item per clock while the result side does not stall.
// An accepted item is held in the input register while the parsing step works
// on it, and its result is then loaded into the result register. Stalls on the
// result side hold both registers; the input side stops taking items once the
// input register holds an item that cannot advance.
// The user must write configuration through the cfg port only while no item
// is in flight; the block itself does not enforce this.

module nfc_response_frame_checker_core
  import nfc_rfc_pkg::*;
#(
  parameter int FRAME_BUFFER_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  s_tuser,   // [0] first_byte
  // Result items.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] payload_byte, [13:8] payload_index,
                                      // [15:14] verdict_status, [21:16] payload_length
  output logic [1:0]       m_tuser,   // [0] payload_valid, [1] verdict_done
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  cfg_t       cfg;
  res_t       res;
  res_t       out_res;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       advance;

  // The parser steps whenever an item waits in the input register and the result register can take its result.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte  <= s_tdata;
      in_first <= s_tuser[0];
    end
  end

  nfc_rfc_cfg #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  nfc_rfc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .rx_byte    (in_byte),
    .first_byte (in_first),
    .cfg        (cfg),
    .res        (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.payload_length, out_res.verdict_status,
                    out_res.payload_index, out_res.payload_byte};
  assign m_tuser = {out_res.verdict_done, out_res.payload_valid};

  // A payload byte and a verdict never share one result item.
  `NFC_RFC_ASSERT_NOW(a_payload_xor_verdict, clk, rst,
    m_tvalid && out_res.payload_valid, !out_res.verdict_done)
  // Without a verdict the status reads as ok.
  `NFC_RFC_ASSERT_NOW(a_status_idle_zero, clk, rst,
    m_tvalid && !out_res.verdict_done, out_res.verdict_status == ST_OK)
  // A payload length is only given with an ok verdict.
  `NFC_RFC_ASSERT_NOW(a_length_only_ok, clk, rst,
    m_tvalid && (out_res.payload_length != 6'd0),
    out_res.verdict_done && (out_res.verdict_status == ST_OK))
  // Every parsing step leaves a result waiting in the next cycle.
  `NFC_RFC_ASSERT_NEXT(a_step_gives_result, clk, rst, advance, m_tvalid)

endmodule

`default_nettype wire
